// ===== sv/rstp_pkg.sv =====
// Shared types and constants for the range scan to points block.
`timescale 1ns / 1ps

package rstp_pkg;

    // Configuration data bus and fixed register widths
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_RANGE_W = 20;
    localparam int CFG_ANGLE_W = 16;
    localparam int INTEN_W     = 16;

    // Sine evaluation in a 16-bit phase domain
    localparam int PHASE_W   = 16;
    localparam int QTR_W     = 14;
    localparam int SIN_MAG_W = 15;
    localparam int SINE_LAT  = 4;

    localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;
    localparam logic [QTR_W:0]     QUARTER_ONE  = 15'd16384;

    // Quarter-wave polynomial coefficients, Q16
    localparam logic [16:0] SIN_QA = 17'd102944;
    localparam logic [15:0] SIN_QB = 16'd42047;
    localparam logic [12:0] SIN_QC = 13'd4640;

    localparam logic [SIN_MAG_W-1:0] SIN_MAG_MAX = 15'h7FFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_RANGE   = 3'd0,
        CFG_MAX_RANGE   = 3'd1,
        CFG_START_ANGLE = 3'd2,
        CFG_ANGLE_STEP  = 3'd3,
        CFG_INTEN_EN    = 3'd4
    } cfg_idx_t;

    // Sine magnitude with quadrant sign
    typedef struct packed {
        logic                 neg;
        logic [SIN_MAG_W-1:0] mag;
    } sine_t;

endpackage

// ===== sv/rstp_front.sv =====
// Configuration registers, beam angle tracking, range gate and input register.
`timescale 1ns / 1ps

module rstp_front
    import rstp_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int RANGE_BITS = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  adv,
    input  logic                  s_accept,
    input  logic [RANGE_BITS-1:0] s_echo_range,
    input  logic                  s_has_echo,
    input  logic [INTEN_W-1:0]    s_beam_intensity,
    input  logic                  s_scan_start,
    output logic [PHASE_W-1:0]    phase_reg,
    output logic [RANGE_BITS-1:0] range_reg,
    output logic [INTEN_W-1:0]    inten_reg,
    output logic                  keep_reg
);

    localparam int CMP_W = (RANGE_BITS > CFG_RANGE_W) ? RANGE_BITS : CFG_RANGE_W;

    logic [CFG_RANGE_W-1:0] min_range_reg;
    logic [CFG_RANGE_W-1:0] max_range_reg;
    logic [CFG_ANGLE_W-1:0] start_angle_reg;
    logic [CFG_ANGLE_W-1:0] angle_step_reg;
    logic                   inten_en_reg;
    logic [ANGLE_BITS-1:0]  beam_angle_reg;
    logic [ANGLE_BITS-1:0]  beam_angle_next;

    logic [ANGLE_BITS+CFG_ANGLE_W-1:0] start_wide;
    logic [ANGLE_BITS+CFG_ANGLE_W-1:0] step_wide;
    logic [ANGLE_BITS-1:0]             angle_cur;
    logic [PHASE_W-1:0]                phase_cur;
    logic [CMP_W-1:0]                  range_cmp;
    logic                              in_window;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_range_reg   <= '0;
            max_range_reg   <= '1;
            start_angle_reg <= '0;
            angle_step_reg  <= '0;
            inten_en_reg    <= 1'b0;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_MIN_RANGE:   min_range_reg   <= cfg_data[CFG_RANGE_W-1:0];
                CFG_MAX_RANGE:   max_range_reg   <= cfg_data[CFG_RANGE_W-1:0];
                CFG_START_ANGLE: start_angle_reg <= cfg_data[CFG_ANGLE_W-1:0];
                CFG_ANGLE_STEP:  angle_step_reg  <= cfg_data[CFG_ANGLE_W-1:0];
                CFG_INTEN_EN:    inten_en_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Scan start reloads the angle for this same beam
    always_comb begin
        start_wide      = {{ANGLE_BITS{1'b0}}, start_angle_reg};
        step_wide       = {{ANGLE_BITS{angle_step_reg[CFG_ANGLE_W-1]}}, angle_step_reg};
        angle_cur       = s_scan_start ? start_wide[ANGLE_BITS-1:0] : beam_angle_reg;
        beam_angle_next = angle_cur + step_wide[ANGLE_BITS-1:0];
        range_cmp       = CMP_W'(s_echo_range);
        in_window       = (CMP_W'(min_range_reg) <= range_cmp) &&
                          (range_cmp <= CMP_W'(max_range_reg));
    end

    generate
        if (ANGLE_BITS >= PHASE_W) begin : g_phase_down
            assign phase_cur = angle_cur[ANGLE_BITS-1 -: PHASE_W];
        end else begin : g_phase_up
            assign phase_cur = {angle_cur, {(PHASE_W-ANGLE_BITS){1'b0}}};
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beam_angle_reg <= '0;
            keep_reg       <= 1'b0;
        end else begin
            if (s_accept) begin
                beam_angle_reg <= beam_angle_next;
            end
            if (adv) begin
                keep_reg <= s_accept && s_has_echo && in_window;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            phase_reg <= phase_cur;
            range_reg <= s_echo_range;
            inten_reg <= inten_en_reg ? s_beam_intensity : '0;
        end
    end

endmodule

// ===== sv/rstp_sine.sv =====
// Pipelined fixed-point sine: quadrant fold and quarter-wave polynomial.
`timescale 1ns / 1ps

module rstp_sine
    import rstp_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic [PHASE_W-1:0] phase,
    output sine_t              res_reg
);

    logic [QTR_W:0]  x_fold;
    logic [29:0]     sq_prod;
    logic [QTR_W:0]  x1_reg, x2_reg, x3_reg;
    logic [QTR_W:0]  t2_1_reg, t2_2_reg;
    logic            neg1_reg, neg2_reg, neg3_reg;
    logic [27:0]     c_prod;
    logic [15:0]     inner2_reg;
    logic [30:0]     b_prod;
    logic [16:0]     mid3_reg;
    logic [31:0]     a_prod;
    logic [31:0]     a_round;

    // Odd quadrants mirror the quarter wave
    always_comb begin
        x_fold  = phase[QTR_W] ? (QUARTER_ONE - {1'b0, phase[QTR_W-1:0]})
                               : {1'b0, phase[QTR_W-1:0]};
        sq_prod = 30'(x_fold) * 30'(x_fold);
        c_prod  = 28'(t2_1_reg) * 28'(SIN_QC);
        b_prod  = 31'(t2_2_reg) * 31'(inner2_reg);
        a_prod  = 32'(x3_reg) * 32'(mid3_reg);
        a_round = a_prod + 32'(QUARTER_ONE);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg     <= x_fold;
            t2_1_reg   <= sq_prod[28:14];
            neg1_reg   <= phase[PHASE_W-1];

            x2_reg     <= x1_reg;
            t2_2_reg   <= t2_1_reg;
            inner2_reg <= SIN_QB - 16'(c_prod[26:14]);
            neg2_reg   <= neg1_reg;

            x3_reg     <= x2_reg;
            mid3_reg   <= SIN_QA - 17'(b_prod[29:14]);
            neg3_reg   <= neg2_reg;

            // Round half up, saturate at full scale
            res_reg.neg <= neg3_reg;
            res_reg.mag <= a_round[30] ? SIN_MAG_MAX : a_round[29:15];
        end
    end

endmodule

// ===== sv/rstp_scale.sv =====
// Range scaling of sine and cosine, rounding, and the output register.
`timescale 1ns / 1ps

module rstp_scale
    import rstp_pkg::*;
#(
    parameter int RANGE_BITS = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  keep,
    input  logic [RANGE_BITS-1:0] range_in,
    input  logic [INTEN_W-1:0]    inten_in,
    input  sine_t                 cos_in,
    input  sine_t                 sin_in,
    output logic                  adv,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [RANGE_BITS:0]   m_point_x,
    output logic [RANGE_BITS:0]   m_point_y,
    output logic [INTEN_W-1:0]    m_point_intensity
);

    localparam int PROD_W = RANGE_BITS + SIN_MAG_W;

    logic                  m_valid_reg;
    logic [RANGE_BITS:0]   x_reg, y_reg, x_next, y_next;
    logic [INTEN_W-1:0]    inten_reg;
    logic [PROD_W-1:0]     x_prod, y_prod, x_round, y_round;
    logic [RANGE_BITS:0]   x_mag, y_mag;

    // Whole pipeline moves when the output register is free or being drained
    assign adv = !m_valid_reg || m_ready;

    always_comb begin
        x_prod  = PROD_W'(range_in) * PROD_W'(cos_in.mag);
        y_prod  = PROD_W'(range_in) * PROD_W'(sin_in.mag);
        x_round = x_prod + PROD_W'(QUARTER_ONE);
        y_round = y_prod + PROD_W'(QUARTER_ONE);
        x_mag   = {1'b0, x_round[PROD_W-1:SIN_MAG_W]};
        y_mag   = {1'b0, y_round[PROD_W-1:SIN_MAG_W]};
        x_next  = cos_in.neg ? (~x_mag + 1'b1) : x_mag;
        y_next  = sin_in.neg ? (~y_mag + 1'b1) : y_mag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            inten_reg <= inten_in;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_point_x         = x_reg;
    assign m_point_y         = y_reg;
    assign m_point_intensity = inten_reg;

endmodule

// ===== sv/range_scan_to_points.sv =====
// Top level: planar scan beams to range-gated Cartesian points.
//
//  Channel | Direction | Handshake          | Payload
//  s_      | in        | s_valid / s_ready  | echo_range, has_echo, beam_intensity, scan_start
//  m_      | out       | m_valid / m_ready  | point_x, point_y, point_intensity
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One beam is taken per cycle while s_ready is high; on its way to m_ its point passes the
// input register, four sine polynomial stages, then scale into the output register.
// All stages move together; they hold only while the output register is full and
// m_ready is low, so s_ready is low exactly then. Beams outside the gate leave no point.
// Reset is synchronous on aresetn; config writes are always ready.
`timescale 1ns / 1ps

module range_scan_to_points
    import rstp_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int RANGE_BITS = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [RANGE_BITS-1:0] s_echo_range,
    input  logic                  s_has_echo,
    input  logic [INTEN_W-1:0]    s_beam_intensity,
    input  logic                  s_scan_start,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [RANGE_BITS:0]   m_point_x,
    output logic [RANGE_BITS:0]   m_point_y,
    output logic [INTEN_W-1:0]    m_point_intensity
);

    logic                  adv;
    logic                  s_accept;
    logic [PHASE_W-1:0]    phase_reg;
    logic [PHASE_W-1:0]    cos_phase;
    logic [RANGE_BITS-1:0] range_reg;
    logic [INTEN_W-1:0]    inten_reg;
    logic                  keep_reg;
    sine_t                 sin_res;
    sine_t                 cos_res;

    logic                  keep_pipe_reg  [SINE_LAT];
    logic [RANGE_BITS-1:0] range_pipe_reg [SINE_LAT];
    logic [INTEN_W-1:0]    inten_pipe_reg [SINE_LAT];

    assign cfg_ready = 1'b1;
    assign s_ready   = adv;
    assign s_accept  = s_valid && adv;
    assign cos_phase = phase_reg + QUARTER_TURN;

    rstp_front #(
        .ANGLE_BITS (ANGLE_BITS),
        .RANGE_BITS (RANGE_BITS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_write        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .adv              (adv),
        .s_accept         (s_accept),
        .s_echo_range     (s_echo_range),
        .s_has_echo       (s_has_echo),
        .s_beam_intensity (s_beam_intensity),
        .s_scan_start     (s_scan_start),
        .phase_reg        (phase_reg),
        .range_reg        (range_reg),
        .inten_reg        (inten_reg),
        .keep_reg         (keep_reg)
    );

    rstp_sine u_sin (
        .aclk    (aclk),
        .en      (adv),
        .phase   (phase_reg),
        .res_reg (sin_res)
    );

    rstp_sine u_cos (
        .aclk    (aclk),
        .en      (adv),
        .phase   (cos_phase),
        .res_reg (cos_res)
    );

    // Carry range, intensity and the point flag alongside the sine stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SINE_LAT; i++) begin
                keep_pipe_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            keep_pipe_reg[0] <= keep_reg;
            for (int i = 1; i < SINE_LAT; i++) begin
                keep_pipe_reg[i] <= keep_pipe_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            range_pipe_reg[0] <= range_reg;
            inten_pipe_reg[0] <= inten_reg;
            for (int i = 1; i < SINE_LAT; i++) begin
                range_pipe_reg[i] <= range_pipe_reg[i-1];
                inten_pipe_reg[i] <= inten_pipe_reg[i-1];
            end
        end
    end

    rstp_scale #(
        .RANGE_BITS (RANGE_BITS)
    ) u_scale (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .keep              (keep_pipe_reg[SINE_LAT-1]),
        .range_in          (range_pipe_reg[SINE_LAT-1]),
        .inten_in          (inten_pipe_reg[SINE_LAT-1]),
        .cos_in            (cos_res),
        .sin_in            (sin_res),
        .adv               (adv),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_point_x         (m_point_x),
        .m_point_y         (m_point_y),
        .m_point_intensity (m_point_intensity)
    );

endmodule
